// ----- hw/rtl/ats_pkg.sv -----
// Shared types and constants of the array table search, delete and sort block.
// Used by the channel interfaces, the table cell, the sequencer and the top level.
package ats_pkg;

    localparam int CAPACITY  = 32;
    localparam int WORD_BITS = 32;

    localparam int IDX_W = $clog2(CAPACITY);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    localparam int OP_W     = 3;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 5;
    localparam int STATUS_W = 2;
    localparam int POS_W    = 6;
    localparam int COUNT_W  = 6;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(CAPACITY - 1);

    typedef logic signed [WORD_BITS-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_CLEAR  = 3'd0,
        OP_APPEND = 3'd1,
        OP_SEARCH = 3'd2,
        OP_DELETE = 3'd3,
        OP_SORT   = 3'd4,
        OP_READ   = 3'd5
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_SORT,
        S_DONE
    } state_t;

    // Commands from the sequencer that the top level decodes for each cell.
    typedef struct packed {
        logic             append_en;
        logic             rotate;
        logic             shift_del;
        logic             sort_en;
        logic             sort_odd;
        logic [CNT_W-1:0] count;
        logic [CNT_W-1:0] del_pos;
    } seq_ctrl_t;

    // Per-cell command.
    typedef struct packed {
        logic load;
        logic take_right;
        logic sort_right;
        logic sort_left;
    } cell_ctrl_t;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic [POS_W-1:0]          position;
        logic [COUNT_W-1:0]        count;
        logic signed [VALUE_W-1:0] read_value;
    } rsp_t;

endpackage

// ----- hw/rtl/ats_if.sv -----
// Request and response channel interfaces of the table block.
// Depends on ats_pkg for the field widths.
interface ats_req_if
    import ats_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [OP_W-1:0]           operation;
    logic signed [VALUE_W-1:0] value;
    logic [INDEX_W-1:0]        index;

    modport source (output valid, output operation, output value, output index, input ready);
    modport sink (input valid, input operation, input value, input index, output ready);
endinterface

interface ats_rsp_if
    import ats_pkg::*;
();
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       status;
    logic [POS_W-1:0]          position;
    logic [COUNT_W-1:0]        count;
    logic signed [VALUE_W-1:0] read_value;

    modport source (output valid, output status, output position, output count,
                    output read_value, input ready);
    modport sink (input valid, input status, input position, input count,
                  input read_value, output ready);
endinterface

// ----- hw/rtl/ats_cell.sv -----
// One table cell: holds a single entry and trades it with its neighbors.
// Depends on ats_pkg for word_t and cell_ctrl_t.
module ats_cell
    import ats_pkg::*;
(
    input  logic       clk,
    input  cell_ctrl_t ctrl,
    input  word_t      new_word,
    input  word_t      left_word,
    input  word_t      right_word,
    output word_t      word
);

    word_t word_reg;
    word_t word_next;

    // In a sort phase the lower cell of a pair keeps the minimum and the
    // upper cell keeps the maximum, so each pair is one compare and swap.
    always_comb
    begin
        if (ctrl.load)
        begin
            word_next = new_word;
        end
        else if (ctrl.take_right)
        begin
            word_next = right_word;
        end
        else if (ctrl.sort_right)
        begin
            word_next = (word_reg > right_word) ? right_word : word_reg;
        end
        else if (ctrl.sort_left)
        begin
            word_next = (left_word > word_reg) ? left_word : word_reg;
        end
        else
        begin
            word_next = word_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule

// ----- hw/rtl/ats_seq.sv -----
// Operation sequencer: handshake, entry count, scan and sort stepping, result register.
// Depends on ats_pkg for the operation codes, states and control structs.
module ats_seq
    import ats_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [OP_W-1:0]    operation,
    input  word_t              word,
    input  logic [INDEX_W-1:0] index,
    input  word_t              head_word,
    output seq_ctrl_t          ctrl,
    output logic               rsp_valid,
    input  logic               rsp_ready,
    output rsp_t               rsp
);

    state_t             state_reg, state_next;
    logic [IDX_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rsp_valid_reg, rsp_valid_next;
    op_t                op_reg, op_next;
    word_t              word_reg, word_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic               found_reg, found_next;
    logic [CNT_W-1:0]   pos_reg, pos_next;
    logic               full_reg, full_next;
    word_t              rv_reg, rv_next;
    rsp_t               rsp_reg, rsp_next;

    logic    accept;
    logic    is_full;
    logic    in_range;
    logic    head_hit;
    logic    leave_done;
    status_t status_done;

    assign accept     = req_valid && req_ready;
    assign is_full    = (count_reg >= CNT_W'(CAPACITY));
    assign in_range   = (32'(idx_reg) < 32'(count_reg));
    assign head_hit   = (CNT_W'(step_reg) < count_reg) && (head_word == word_reg);
    assign leave_done = (state_reg == S_DONE) && (!rsp_valid_reg || rsp_ready);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    unique case (operation) inside
                        OP_SEARCH, OP_DELETE, OP_READ: state_next = S_SCAN;
                        OP_SORT:                       state_next = S_SORT;
                        default:                       state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = (op_reg == OP_DELETE) ? S_SHIFT : S_DONE;
                end
            end
            S_SHIFT:
            begin
                state_next = S_DONE;
            end
            S_SORT:
            begin
                if (step_reg == LAST_STEP)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (leave_done)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Outputs toward the cells and the request side.
    always_comb
    begin
        req_ready      = (state_reg == S_IDLE);
        ctrl.append_en = accept && (operation == OP_APPEND) && !is_full;
        ctrl.rotate    = (state_reg == S_SCAN);
        ctrl.shift_del = (state_reg == S_SHIFT) && found_reg;
        ctrl.sort_en   = (state_reg == S_SORT);
        ctrl.sort_odd  = step_reg[0];
        ctrl.count     = count_reg;
        ctrl.del_pos   = pos_reg;
    end

    // Status of the finished operation.
    always_comb
    begin
        case (op_reg) inside
            OP_APPEND:            status_done = full_reg ? ST_FULL : ST_OK;
            OP_SEARCH, OP_DELETE: status_done = found_reg ? ST_OK : ST_NOT_FOUND;
            OP_READ:              status_done = in_range ? ST_OK : ST_RANGE;
            default:              status_done = ST_OK;
        endcase
    end

    always_comb
    begin
        step_next      = step_reg;
        count_next     = count_reg;
        op_next        = op_reg;
        word_next      = word_reg;
        idx_next       = idx_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        full_next      = full_reg;
        rv_next        = rv_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg;

        if (accept)
        begin
            step_next  = '0;
            op_next    = op_t'(operation);
            word_next  = word;
            idx_next   = index;
            found_next = 1'b0;
            pos_next   = '0;
            full_next  = is_full;
            if (operation == OP_CLEAR)
            begin
                count_next = '0;
            end
            else if (ctrl.append_en)
            begin
                count_next = count_reg + 1'b1;
            end
        end

        if ((state_reg == S_SCAN) || (state_reg == S_SORT))
        begin
            step_next = step_reg + 1'b1;
        end

        // The head cell shows entry number step during the rotation.
        if (state_reg == S_SCAN)
        begin
            if ((op_reg == OP_SEARCH || op_reg == OP_DELETE) && head_hit && !found_reg)
            begin
                found_next = 1'b1;
                pos_next   = CNT_W'(step_reg) + 1'b1;
            end
            if ((op_reg == OP_READ) && (32'(step_reg) == 32'(idx_reg)))
            begin
                rv_next = head_word;
            end
        end

        if (ctrl.shift_del)
        begin
            count_next = count_reg - 1'b1;
        end

        if (leave_done)
        begin
            rsp_next.status     = status_done;
            rsp_next.position   = POS_W'(pos_reg);
            rsp_next.count      = COUNT_W'(count_reg);
            rsp_next.read_value = ((op_reg == OP_READ) && in_range) ? VALUE_W'(rv_reg) : '0;
            rsp_valid_next      = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        op_reg    <= op_next;
        word_reg  <= word_next;
        idx_reg   <= idx_next;
        found_reg <= found_next;
        pos_reg   <= pos_next;
        full_reg  <= full_next;
        rv_reg    <= rv_next;
        rsp_reg   <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ----- hw/rtl/array_table_search_delete_sort.sv -----
// Bounded table of signed words: clear, append, search, delete, sort, read.
// One request at a time; the next is taken once the previous response is registered.
// The cost is the CAPACITY-step rotation of the cell ring (search, delete, read) or
// CAPACITY odd-even sort phases. Reset (rst_n, asynchronous, active low) empties
// the table; entries keep no reset.
module array_table_search_delete_sort
    import ats_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    ats_req_if.sink   req,
    ats_rsp_if.source rsp
);

    seq_ctrl_t  ctrl;
    rsp_t       rsp_data;
    word_t      new_word;
    word_t      cell_word [CAPACITY];
    cell_ctrl_t cell_ctrl [CAPACITY];

    assign new_word = word_t'(req.value);

    ats_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .operation (req.operation),
        .word      (new_word),
        .index     (req.index),
        .head_word (cell_word[0]),
        .ctrl      (ctrl),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .rsp       (rsp_data)
    );

    assign rsp.status     = rsp_data.status;
    assign rsp.position   = rsp_data.position;
    assign rsp.count      = rsp_data.count;
    assign rsp.read_value = rsp_data.read_value;

    // The ring closes from the last cell back to the first, so a full rotation
    // returns every entry to its own cell.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        localparam logic EVEN = (i % 2 == 0);

        always_comb
        begin
            cell_ctrl[i].load       = ctrl.append_en && (ctrl.count == CNT_W'(i));
            cell_ctrl[i].take_right = ctrl.rotate
                                      || (ctrl.shift_del && (CNT_W'(i + 1) >= ctrl.del_pos));
            cell_ctrl[i].sort_right = ctrl.sort_en && ((EVEN && !ctrl.sort_odd)
                                      || (!EVEN && ctrl.sort_odd))
                                      && (CNT_W'(i + 1) < ctrl.count);
            cell_ctrl[i].sort_left  = ctrl.sort_en && (i != 0) && ((!EVEN && !ctrl.sort_odd)
                                      || (EVEN && ctrl.sort_odd))
                                      && (CNT_W'(i) < ctrl.count);
        end

        ats_cell u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl[i]),
            .new_word   (new_word),
            .left_word  (cell_word[(i + CAPACITY - 1) % CAPACITY]),
            .right_word (cell_word[(i + 1) % CAPACITY]),
            .word       (cell_word[i])
        );
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.count <= CNT_W'(CAPACITY))
        else $error("entry count beyond capacity");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> !req.ready)
        else $error("request taken while an operation is in progress");

    a_one_cell_op: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctrl.append_en, ctrl.rotate, ctrl.shift_del, ctrl.sort_en}))
        else $error("conflicting cell commands");

    a_count_reported: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> (32'(rsp.count) == 32'(ctrl.count)))
        else $error("reported count differs from table count");
`endif

endmodule
